### rtl/core/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_WIDTH  = 4;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Derived widths.
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int POS_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int TAB_W  = $clog2(TAB_WIDTH + 1);

    // Port field widths.
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Attribute after reset.
    localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET = 8'd15;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    typedef logic [CURSOR_W-1:0] t_cursor;

    // Classified operation handed from front to back.
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_TAB,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        logic              in_range;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/core/tcw_front.sv
`default_nettype none

module tcw_front (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [tcw_pkg::KIND_W-1:0]   i_kind,
    input  wire [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  wire [tcw_pkg::INDEX_W-1:0]  i_cell_index,
    input  wire                         i_hold,
    input  wire                         i_cmd_pop,
    output logic                        o_busy,
    output logic                        o_cmd_valid,
    output tcw_pkg::t_cmd               o_cmd
);

    tcw_pkg::t_cmd                    r_queue [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [tcw_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [tcw_pkg::QCNT_W-1:0]       r_count;
    tcw_pkg::t_cmd                    cmd_in;
    logic                             push;
    logic                             pop;

    // Classify the incoming request into one back-end operation.
    always_comb begin
        cmd_in.ch       = i_char_code;
        cmd_in.addr     = tcw_pkg::ADDR_W'(i_cell_index);
        cmd_in.in_range = (32'(i_cell_index) < tcw_pkg::CELL_COUNT);
        case (i_kind)
            tcw_pkg::KIND_PUT: begin
                case (i_char_code)
                    tcw_pkg::CH_NEWLINE:   cmd_in.op = tcw_pkg::OP_NEWLINE;
                    tcw_pkg::CH_TAB:       cmd_in.op = tcw_pkg::OP_TAB;
                    tcw_pkg::CH_BACKSPACE: cmd_in.op = tcw_pkg::OP_BACKSPACE;
                    default:               cmd_in.op = tcw_pkg::OP_PUT;
                endcase
            end
            tcw_pkg::KIND_CLEAR: cmd_in.op = tcw_pkg::OP_CLEAR;
            tcw_pkg::KIND_READ:  cmd_in.op = tcw_pkg::OP_READ;
            default:             cmd_in.op = tcw_pkg::OP_NONE;
        endcase
    end

    // Accept while the queue has room and the store is not being initialized.
    assign o_busy      = i_hold || (r_count == tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_queue[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/tcw_back.sv
`default_nettype none

module tcw_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cmd_valid,
    input  tcw_pkg::t_cmd               i_cmd,
    input  wire [tcw_pkg::ATTR_W-1:0]   i_attr,
    output logic                        o_cmd_pop,
    output logic                        o_init_busy,
    output logic                        o_strobe,
    output logic [tcw_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]  o_cell_attr,
    output logic [tcw_pkg::CURSOR_W-1:0] o_cursor_pos
);

    localparam int CELL_W = tcw_pkg::ATTR_W + tcw_pkg::CHAR_W;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SETTLE,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL,
        S_EXEC,
        S_CLEAR,
        S_RD_WAIT,
        S_DONE
    } t_state;

    // Screen store.
    logic [CELL_W-1:0]               r_mem [tcw_pkg::CELL_COUNT];
    logic [CELL_W-1:0]               r_rd_data;
    logic                            mem_we;
    logic [tcw_pkg::ADDR_W-1:0]      mem_waddr;
    logic [CELL_W-1:0]               mem_wdata;
    logic [tcw_pkg::ADDR_W-1:0]      mem_raddr;

    // Sequencer state and registered outputs.
    t_state                          r_state, n_state;
    tcw_pkg::t_cmd                   r_cmd, n_cmd;
    logic [tcw_pkg::ADDR_W-1:0]      r_idx, n_idx;
    logic [tcw_pkg::POS_W-1:0]       r_line, n_line;
    logic [tcw_pkg::COL_W-1:0]       r_col, n_col;
    logic [tcw_pkg::TAB_W-1:0]       r_tab, n_tab;
    logic                            r_ret, n_ret;
    logic                            r_strobe, n_strobe;
    logic [tcw_pkg::CHAR_W-1:0]      r_char, n_char;
    logic [tcw_pkg::ATTR_W-1:0]      r_attr, n_attr;
    logic [tcw_pkg::CURSOR_W-1:0]    r_cur, n_cur;

    // Cursor arithmetic.
    logic [tcw_pkg::POS_W-1:0]       pos;
    logic [tcw_pkg::POS_W-1:0]       inc_line;
    logic [tcw_pkg::COL_W-1:0]       inc_col;
    logic [tcw_pkg::POS_W-1:0]       bs_line;
    logic [tcw_pkg::COL_W-1:0]       bs_col;
    logic [tcw_pkg::POS_W-1:0]       bs_pos;
    logic [tcw_pkg::POS_W-1:0]       nl_next;
    logic [CELL_W-1:0]               blank;
    logic                            pos_past_end;

    assign blank        = {i_attr, tcw_pkg::CH_SPACE};
    assign pos          = r_line + tcw_pkg::POS_W'(r_col);
    assign pos_past_end = (pos >= tcw_pkg::POS_W'(tcw_pkg::CELL_COUNT));
    assign nl_next      = r_line + tcw_pkg::POS_W'(tcw_pkg::COLUMNS);

    // Advance by one cell, wrapping into the next row.
    always_comb begin
        if (r_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
            inc_col  = '0;
            inc_line = r_line + tcw_pkg::POS_W'(tcw_pkg::COLUMNS);
        end else begin
            inc_col  = r_col + 1'b1;
            inc_line = r_line;
        end
    end

    // Step back by one cell, holding at the first cell.
    always_comb begin
        if (pos == '0) begin
            bs_col  = '0;
            bs_line = '0;
        end else if (r_col == '0) begin
            bs_col  = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
            bs_line = r_line - tcw_pkg::POS_W'(tcw_pkg::COLUMNS);
        end else begin
            bs_col  = r_col - 1'b1;
            bs_line = r_line;
        end
        bs_pos = bs_line + tcw_pkg::POS_W'(bs_col);
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_line    = r_line;
        n_col     = r_col;
        n_tab     = r_tab;
        n_ret     = r_ret;
        n_strobe  = 1'b0;
        n_char    = r_char;
        n_attr    = r_attr;
        n_cur     = r_cur;
        o_cmd_pop = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = blank;
        mem_raddr = r_idx;
        case (r_state)
            // Zero the whole store after reset.
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_idx == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                mem_raddr = i_cmd.addr;
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_tab     = '0;
                    case (i_cmd.op)
                        tcw_pkg::OP_PUT,
                        tcw_pkg::OP_NEWLINE,
                        tcw_pkg::OP_TAB,
                        tcw_pkg::OP_BACKSPACE: n_state = S_SETTLE;
                        tcw_pkg::OP_CLEAR: begin
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        tcw_pkg::OP_READ:  n_state = S_RD_WAIT;
                        default:           n_state = S_DONE;
                    endcase
                end
            end
            // Scroll first when the cursor sits past the last cell.
            S_SETTLE: begin
                if (pos_past_end) begin
                    n_idx   = '0;
                    n_ret   = 1'b1;
                    n_state = S_SCR_RD;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_SCR_RD: begin
                mem_raddr = tcw_pkg::ADDR_W'(32'(r_idx) + tcw_pkg::COLUMNS);
                n_state   = S_SCR_WR;
            end
            S_SCR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data;
                n_idx     = r_idx + 1'b1;
                if (r_idx == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS - 1)) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_SCR_RD;
                end
            end
            // Blank the last row and move the cursor up one row.
            S_FILL: begin
                mem_we = 1'b1;
                if (r_idx == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
                    n_line  = r_line - tcw_pkg::POS_W'(tcw_pkg::COLUMNS);
                    n_state = r_ret ? S_EXEC : S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EXEC: begin
                case (r_cmd.op)
                    tcw_pkg::OP_NEWLINE: begin
                        n_line = nl_next;
                        n_col  = '0;
                        if (nl_next >= tcw_pkg::POS_W'(tcw_pkg::CELL_COUNT)) begin
                            n_idx   = '0;
                            n_ret   = 1'b0;
                            n_state = S_SCR_RD;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    tcw_pkg::OP_BACKSPACE: begin
                        mem_we    = 1'b1;
                        mem_waddr = tcw_pkg::ADDR_W'(bs_pos);
                        n_line    = bs_line;
                        n_col     = bs_col;
                        n_state   = S_DONE;
                    end
                    tcw_pkg::OP_TAB: begin
                        mem_we    = 1'b1;
                        mem_waddr = tcw_pkg::ADDR_W'(pos);
                        n_line    = inc_line;
                        n_col     = inc_col;
                        if (r_tab == tcw_pkg::TAB_W'(tcw_pkg::TAB_WIDTH - 1)) begin
                            n_state = S_DONE;
                        end else begin
                            n_tab   = r_tab + 1'b1;
                            n_state = S_SETTLE;
                        end
                    end
                    default: begin
                        mem_we    = 1'b1;
                        mem_waddr = tcw_pkg::ADDR_W'(pos);
                        mem_wdata = {i_attr, r_cmd.ch};
                        n_line    = inc_line;
                        n_col     = inc_col;
                        n_state   = S_DONE;
                    end
                endcase
            end
            // Blank every cell, then home the cursor.
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_idx == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
                    n_line  = '0;
                    n_col   = '0;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_RD_WAIT: begin
                n_strobe = 1'b1;
                n_char   = r_cmd.in_range ? r_rd_data[tcw_pkg::CHAR_W-1:0] : '0;
                n_attr   = r_cmd.in_range ? r_rd_data[CELL_W-1:tcw_pkg::CHAR_W] : '0;
                n_cur    = tcw_pkg::t_cursor'(pos);
                n_state  = S_IDLE;
            end
            S_DONE: begin
                n_strobe = 1'b1;
                n_char   = '0;
                n_attr   = '0;
                n_cur    = tcw_pkg::t_cursor'(pos);
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Store write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_idx    <= '0;
            r_line   <= '0;
            r_col    <= '0;
            r_tab    <= '0;
            r_ret    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_line   <= n_line;
            r_col    <= n_col;
            r_tab    <= n_tab;
            r_ret    <= n_ret;
            r_strobe <= n_strobe;
        end
        r_cmd  <= n_cmd;
        r_char <= n_char;
        r_attr <= n_attr;
        r_cur  <= n_cur;
    end

    assign o_init_busy  = (r_state == S_INIT);
    assign o_strobe     = r_strobe;
    assign o_cell_char  = r_char;
    assign o_cell_attr  = r_attr;
    assign o_cursor_pos = r_cur;

endmodule

`default_nettype wire

### rtl/core/text_console_writer_unit.sv
// Text console writer. A request is taken when start is high and busy is low;
// each request yields exactly one result, shown for a single cycle with
// o_result_strobe high, and the receiver cannot stall it. A two-entry queue
// sits between the request decoder and the screen sequencer, so up to two
// requests may be taken while the sequencer is working. The screen store has
// one write and one registered read port. A scroll copies each row up by one
// and blanks the last row; a newline may need two scrolls. A clear blanks
// every cell and homes the cursor. After reset the store is zeroed in one
// pass during which busy stays high; configuration writes are taken at any
// time and should be made only while no request is pending.
`default_nettype none

module text_console_writer_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wire [tcw_pkg::KIND_W-1:0]      i_kind,
    input  wire [tcw_pkg::CHAR_W-1:0]      i_char_code,
    input  wire [tcw_pkg::INDEX_W-1:0]     i_cell_index,
    output logic                           o_result_strobe,
    output logic [tcw_pkg::CHAR_W-1:0]     o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]     o_cell_attr,
    output logic [tcw_pkg::CURSOR_W-1:0]   o_cursor_pos,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [tcw_pkg::ATTR_W-1:0]      i_cfg_data
);

    logic [tcw_pkg::ATTR_W-1:0] r_text_attr;
    tcw_pkg::t_cmd              cmd;
    logic                       cmd_valid;
    logic                       cmd_pop;
    logic                       init_busy;

    // Attribute register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= tcw_pkg::TEXT_ATTR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_text_attr <= i_cfg_data;
        end
    end

    // Request decoder and queue.
    tcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_kind       (i_kind),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_hold       (init_busy),
        .i_cmd_pop    (cmd_pop),
        .o_busy       (busy),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    // Screen sequencer and store.
    tcw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .i_attr       (r_text_attr),
        .o_cmd_pop    (cmd_pop),
        .o_init_busy  (init_busy),
        .o_strobe     (o_result_strobe),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_cursor_pos (o_cursor_pos)
    );

endmodule

`default_nettype wire

### rtl/core/tcw_checker.sv
`default_nettype none

module tcw_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          busy,
    input wire                          o_result_strobe,
    input wire [tcw_pkg::CURSOR_W-1:0]  o_cursor_pos
);

    // The store is being zeroed right after reset, so no request is taken.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // No result leaves in the cycle after reset.
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_strobe)
        else $error("result strobe right after reset");

    // The sequencer returns to idle between results.
    a_strobe_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("results in back-to-back cycles");

    // The reported cursor never passes the end of the screen.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (32'(o_cursor_pos) <= tcw_pkg::CELL_COUNT))
        else $error("cursor past the end of the screen");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_cursor_pos    (o_cursor_pos)
);

`default_nettype wire
